@@ design/cist_pkg.sv @@
// Shared types and constants for the card identifier slot table.
package cist_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 16;
    localparam int unsigned UID_W         = 32;
    localparam int unsigned SLOT_W        = 4;
    localparam int unsigned ACT_W         = 2;
    localparam int unsigned STAT_W        = 2;

    localparam logic [UID_W-1:0] MASTER_UID_RST = 32'h5B79_C810;

    localparam logic [ACT_W-1:0] ACT_FIND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // Request travelling down the cell chain.
    typedef struct packed {
        logic              valid;
        logic [ACT_W-1:0]  action;
        logic [UID_W-1:0]  uid;
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_wave;

endpackage

@@ design/cist_cell.sv @@
// One table slot: holds an identifier and its present mark, serves the passing request.
module cist_cell
    import cist_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_wave i_wave,
    output t_wave o_wave
);

    localparam logic              CLR_REACH = (CELL_IDX < (2 ** SLOT_W));
    localparam logic [SLOT_W-1:0] IDX_LO    = CELL_IDX[SLOT_W-1:0];

    logic [UID_W-1:0] r_id;
    logic [UID_W-1:0] n_id;
    logic             r_present;
    logic             n_present;
    t_wave            r_wave;
    t_wave            n_wave;

    always_comb begin
        n_wave    = i_wave;
        n_id      = r_id;
        n_present = r_present;
        if (i_wave.valid && !i_wave.hit) begin
            case (i_wave.action)
                ACT_FIND: begin
                    if (r_present && (r_id == i_wave.uid)) begin
                        n_wave.hit = 1'b1;
                        n_wave.idx = IDX_LO;
                    end
                end
                ACT_ADD: begin
                    if (!r_present) begin
                        n_id       = i_wave.uid;
                        n_present  = 1'b1;
                        n_wave.hit = 1'b1;
                        n_wave.idx = IDX_LO;
                    end
                end
                ACT_CLEAR: begin
                    if (CLR_REACH && (i_wave.slot == IDX_LO)) begin
                        n_id       = '0;
                        n_present  = 1'b0;
                        n_wave.hit = 1'b1;
                        n_wave.idx = IDX_LO;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave    <= '0;
            r_id      <= '0;
            r_present <= 1'b0;
        end else begin
            r_wave    <= n_wave;
            r_id      <= n_id;
            r_present <= n_present;
        end
    end

    assign o_wave = r_wave;

endmodule

@@ design/card_id_slot_table.sv @@
// Top level of the card identifier slot table: cell chain, command port, result register.
//
// A request (find, add or clear) is taken when start is high and busy is low. It then walks
// the chain of NUM_SLOTS slot cells, one cell per cycle, and its result appears on the result
// ports with o_result_valid high for exactly one cycle, registered after the last cell;
// the receiver cannot stall it. busy stays high from the cycle after the request until
// the result cycle, so a new request is not taken until the previous one has left the
// chain. The master identifier may be written through the cfg channel while busy is low;
// it resets to 0x5B79C810. All slots are empty after reset.
module card_id_slot_table
    import cist_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [UID_W-1:0]  i_uid,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_result_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic              o_is_master,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [UID_W-1:0]  i_cfg_data
);

    t_wave                w_wave [NUM_SLOTS+1];
    t_wave                w_head;
    logic [NUM_SLOTS-1:0] w_inflight;
    logic                 w_take;
    t_wave                w_last;

    logic [UID_W-1:0]  r_master;
    logic              r_busy;
    logic              r_res_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [SLOT_W-1:0] r_index;
    logic              r_is_master;

    assign w_take = start && !r_busy;

    always_comb begin
        w_head        = '0;
        w_head.valid  = w_take;
        w_head.action = i_action;
        w_head.uid    = i_uid;
        w_head.slot   = i_slot;
    end

    assign w_wave[0] = w_head;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        cist_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wave  (w_wave[k]),
            .o_wave  (w_wave[k+1])
        );
        assign w_inflight[k] = w_wave[k+1].valid;
    end

    assign w_last = w_wave[NUM_SLOTS];

    always_comb begin
        if (w_last.hit) begin
            n_status = ST_OK;
        end else if (w_last.action == ACT_ADD) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master    <= MASTER_UID_RST;
            r_busy      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_master <= i_cfg_data;
            end
            if (w_take) begin
                r_busy <= 1'b1;
            end else if (w_last.valid) begin
                r_busy <= 1'b0;
            end
            r_res_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_status    <= n_status;
            r_index     <= w_last.hit ? w_last.idx : '0;
            r_is_master <= (w_last.uid == r_master);
        end
    end

    assign busy           = r_busy;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_slot_index   = r_index;
    assign o_is_master    = r_is_master;

`ifndef ASSERT_OFF
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_inflight))
        else $error("more than one request in the cell chain");

    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_busy)
        else $error("busy not raised after request");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !r_busy)
        else $error("result issued while still busy");

    a_inflight_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_inflight != '0) |-> r_busy)
        else $error("request in chain while not busy");

    a_fail_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_status != ST_OK)) |-> (r_index == '0))
        else $error("nonzero slot index on failed request");
`endif

endmodule
